// ===== src/telegram_escape_xor_framer_assert.svh =====
// Assertion macros used by the telegram framer top level
`ifndef TELEGRAM_ESCAPE_XOR_FRAMER_ASSERT_SVH
`define TELEGRAM_ESCAPE_XOR_FRAMER_ASSERT_SVH

// holds whenever cond_a is seen, same cycle
`define TEF_ASSERT_NOW(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error(msg);

// holds in the cycle after cond_a is seen
`define TEF_ASSERT_NEXT(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error(msg);

`endif

// ===== src/tef_pkg.sv =====
// Types, constants and decode functions for the telegram framer
`timescale 1ns / 1ps

package tef_pkg;

    localparam logic [7:0] CHK_SEED = 8'h7F;
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [4:0] NOT_HEX  = 5'd16;

    typedef enum logic [5:0] {
        PH_OPEN = 6'b000001,
        PH_HI   = 6'b000010,
        PH_LO   = 6'b000100,
        PH_WAIT = 6'b001000,
        PH_EMIT = 6'b010000,
        PH_PASS = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       is_chk;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] xr;
        logic       emit;
        logic [7:0] val;
    } feed_t;

    typedef struct packed {
        logic [1:0]       count;
        beat_t [2:0]      entry;
        phase_t           phase;
        logic [7:0]       d1;
        logic [7:0]       d2;
        logic [7:0]       xr;
    } step_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                r = {1'b0, c[3:0]};
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                r = 5'(c[2:0] + 4'd9);
            else
                r = NOT_HEX;
            return r;
        end
    endfunction

    function automatic logic [7:0] decode_digits(input logic [7:0] d1, input logic [7:0] d2);
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] r;
        begin
            hi = hex_value(d1);
            lo = hex_value(d2);
            if (hi == NOT_HEX)
                r = 8'h00;
            else if (lo == NOT_HEX)
                r = {4'h0, hi[3:0]};
            else
                r = {hi[3:0], lo[3:0]};
            return r;
        end
    endfunction

    function automatic feed_t feed(input phase_t ph, input logic [7:0] d1,
                                   input logic [7:0] d2, input logic [7:0] xr,
                                   input logic [7:0] c);
        feed_t  f;
        phase_t p;
        logic [7:0] v;
        begin
            p = ph;
            if (c == CH_OPEN)
                p = PH_OPEN;
            if (c == CH_CLOSE)
                p = PH_EMIT;
            f.phase = p;
            f.d1    = d1;
            f.d2    = d2;
            f.xr    = xr;
            f.emit  = 1'b0;
            f.val   = c;
            v       = decode_digits(d1, d2);
            unique case (p)
                PH_OPEN: f.phase = PH_HI;
                PH_HI:
                begin
                    f.d1    = c;
                    f.phase = PH_LO;
                end
                PH_LO:
                begin
                    f.d2    = c;
                    f.phase = PH_WAIT;
                end
                PH_WAIT: f.phase = PH_EMIT;
                PH_EMIT:
                begin
                    f.emit  = 1'b1;
                    f.val   = v;
                    f.xr    = xr ^ v;
                    f.d1    = 8'h00;
                    f.d2    = 8'h00;
                    f.phase = PH_PASS;
                end
                default:
                begin
                    f.emit  = 1'b1;
                    f.xr    = xr ^ c;
                    f.phase = PH_PASS;
                end
            endcase
            return f;
        end
    endfunction

endpackage

// ===== src/tef_step.sv =====
// Per-character decode: character, trailing CR and checksum into an ordered beat list
`timescale 1ns / 1ps

module tef_step
(
    input  tef_pkg::phase_t phase,
    input  logic [7:0]      d1,
    input  logic [7:0]      d2,
    input  logic [7:0]      xr,
    input  logic [7:0]      char_in,
    input  logic            last,
    output tef_pkg::step_t  step
);

    tef_pkg::feed_t f_char;
    tef_pkg::feed_t f_cr;
    tef_pkg::beat_t r_char;
    tef_pkg::beat_t r_cr;
    tef_pkg::beat_t r_chk;
    logic           p_cr;

    always_comb
    begin
        f_char = tef_pkg::feed(phase, d1, d2, xr, char_in);
        f_cr   = tef_pkg::feed(f_char.phase, f_char.d1, f_char.d2, f_char.xr, tef_pkg::CH_CR);
        p_cr   = last & f_cr.emit;
        r_char = '{is_chk: 1'b0, data: f_char.val};
        r_cr   = '{is_chk: 1'b0, data: f_cr.val};
        r_chk  = '{is_chk: 1'b1, data: (last ? f_cr.xr : f_char.xr)};

        step.count    = 2'({1'b0, f_char.emit} + {1'b0, p_cr} + {1'b0, last});
        step.entry[0] = f_char.emit ? r_char : (p_cr ? r_cr : r_chk);
        step.entry[1] = (f_char.emit && p_cr) ? r_cr : r_chk;
        step.entry[2] = r_chk;
        step.phase    = f_char.phase;
        step.d1       = f_char.d1;
        step.d2       = f_char.d2;
        step.xr       = f_char.xr;
    end

endmodule

// ===== src/tef_out.sv =====
// Output register of the result stream
`timescale 1ns / 1ps

module tef_out
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tef_pkg::beat_t beat,
    output logic           free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // byte_out
    output logic           m_tlast    // is_checksum
);

    logic           valid_reg;
    logic           valid_next;
    tef_pkg::beat_t beat_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = push || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            beat_reg <= beat;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = beat_reg.data;
    assign m_tlast  = beat_reg.is_chk;

endmodule

// ===== src/telegram_escape_xor_framer.sv =====
// Top level of the telegram escape decoder and XOR checksum framer
`timescale 1ns / 1ps
`include "telegram_escape_xor_framer_assert.svh"

// Takes one command character per transaction (s_tlast on the final one) and
// sends raw telegram bytes, escapes of the form <hh> decoded, then a checksum
// byte flagged by m_tlast. Characters are taken one per cycle unless the output
// register is held by back-pressure; each result byte passes through the single
// output register, and the final character of a command gives up to three bytes
// (its own byte, the trailing CR byte and the checksum), holding off further
// characters until they are sent. Characters are registered on input.
module telegram_escape_xor_framer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_in
    input  logic       s_tlast,   // end_of_command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // byte_out
    output logic       m_tlast    // is_checksum
);

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [7:0]      char_reg;
    logic            last_reg;
    tef_pkg::phase_t phase_reg;
    tef_pkg::phase_t phase_next;
    logic [7:0]      d1_reg;
    logic [7:0]      d1_next;
    logic [7:0]      d2_reg;
    logic [7:0]      d2_next;
    logic [7:0]      xr_reg;
    logic [7:0]      xr_next;
    logic [1:0]      beat_reg;
    logic [1:0]      beat_next;
    tef_pkg::step_t  step;
    tef_pkg::beat_t  sel;
    logic            out_free;
    logic            emit;
    logic            consume;
    logic            take;

    tef_step u_step
    (
        .phase   (phase_reg),
        .d1      (d1_reg),
        .d2      (d2_reg),
        .xr      (xr_reg),
        .char_in (char_reg),
        .last    (last_reg),
        .step    (step)
    );

    always_comb
    begin
        unique case (beat_reg)
            2'd0:    sel = step.entry[0];
            2'd1:    sel = step.entry[1];
            default: sel = step.entry[2];
        endcase
    end

    assign emit     = in_valid_reg && (step.count != 2'd0) && out_free;
    assign consume  = in_valid_reg &&
                      ((step.count == 2'd0) || (out_free && (beat_reg == 2'(step.count - 2'd1))));
    assign s_tready = !in_valid_reg || consume;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = take || (in_valid_reg && !consume);
        beat_next     = beat_reg;
        if (consume)
            beat_next = 2'd0;
        else if (emit)
            beat_next = 2'(beat_reg + 2'd1);

        phase_next = phase_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        xr_next    = xr_reg;
        if (consume)
        begin
            if (last_reg)
            begin
                phase_next = tef_pkg::PH_PASS;
                d1_next    = 8'h00;
                d2_next    = 8'h00;
                xr_next    = tef_pkg::CHK_SEED;
            end
            else
            begin
                phase_next = step.phase;
                d1_next    = step.d1;
                d2_next    = step.d2;
                xr_next    = step.xr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            beat_reg     <= 2'd0;
            phase_reg    <= tef_pkg::PH_PASS;
            d1_reg       <= 8'h00;
            d2_reg       <= 8'h00;
            xr_reg       <= tef_pkg::CHK_SEED;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            beat_reg     <= beat_next;
            phase_reg    <= phase_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
            xr_reg       <= xr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    tef_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (emit),
        .beat     (sel),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `TEF_ASSERT_NOW(a_beat_range, 1'b1, beat_reg != 2'd3, "beat index out of range")
    `TEF_ASSERT_NOW(a_beat_item, beat_reg != 2'd0, in_valid_reg && last_reg,
                    "multi-beat without final character")
    `TEF_ASSERT_NEXT(a_end_reset, consume && last_reg,
                     (phase_reg == tef_pkg::PH_PASS) && (xr_reg == tef_pkg::CHK_SEED)
                     && (d1_reg == 8'h00),
                     "state not reset after command end")
    `TEF_ASSERT_NEXT(a_chk_out, emit && sel.is_chk, m_tvalid && m_tlast,
                     "checksum beat lost")

endmodule

// ===== dv/telegram_escape_xor_framer_tb.sv =====
// Self-checking testbench for the telegram escape decoder and XOR checksum framer
`timescale 1ns / 1ps

module telegram_escape_xor_framer_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int N_RANDOM    = 205;
    localparam int QUIET_TAIL  = 40;
    localparam int N_DIRECTED  = 25;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] n_typed;
        logic [7:0] t0;
        logic [7:0] t1;
        logic [7:0] t2;
    } cmd_char_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // char_in
    logic       s_tlast;   // end_of_command
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // byte_out
    logic       m_tlast;   // is_checksum

    cmd_char_t       cmd_chars[$];
    tef_pkg::beat_t  pending_bytes[$];
    tef_pkg::beat_t  char_bytes[$];

    // decoder state mirror
    tef_pkg::phase_t esc_phase;
    logic [7:0]      hi_char;
    logic [7:0]      lo_char;
    logic [7:0]      xor_acc;

    int         sent = 0;
    int         shown_idx = -1;
    int         src_gap = 0;
    int         snk_gap = 0;
    int         n_errors = 0;
    int         n_bytes = 0;
    int         n_checksums = 0;
    int         n_escapes = 0;
    int         stall_cycles = 0;

    cmd_char_t  directed_tab [N_DIRECTED] = '{
        '{8'h41,             1'b0, 2'd1, 8'h41, 8'h00, 8'h00},
        '{8'hFF,             1'b0, 2'd1, 8'hFF, 8'h00, 8'h00},
        '{8'h00,             1'b1, 2'd3, 8'h00, 8'h0D, 8'hCC},
        '{tef_pkg::CH_OPEN,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h61,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h46,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_OPEN,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h47,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_OPEN,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h37,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h7A,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_OPEN,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h35,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_OPEN,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_OPEN,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h31,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h32,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h78,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h79,             1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{tef_pkg::CH_OPEN,  1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h42,             1'b1, 2'd3, 8'h42, 8'h0D, 8'h30}
    };

    telegram_escape_xor_framer u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // 16 flags a non-hex character
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 5'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46)
            return 5'(c - 8'h41 + 8'd10);
        if (c >= 8'h61 && c <= 8'h66)
            return 5'(c - 8'h61 + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] hi;
        logic [4:0] lo;
        hi = nibble_of(a);
        lo = nibble_of(b);
        if (hi[4])
            return 8'h00;
        if (lo[4])
            return {4'h0, hi[3:0]};
        return {hi[3:0], lo[3:0]};
    endfunction

    task automatic clear_decoder();
        esc_phase = tef_pkg::PH_PASS;
        hi_char   = 8'h00;
        lo_char   = 8'h00;
        xor_acc   = tef_pkg::CHK_SEED;
    endtask

    task automatic decode_char(input logic [7:0] c);
        logic [7:0]     v;
        tef_pkg::beat_t b;
        if (c == tef_pkg::CH_OPEN)
            esc_phase = tef_pkg::PH_OPEN;
        if (c == tef_pkg::CH_CLOSE)
            esc_phase = tef_pkg::PH_EMIT;
        case (esc_phase)
            tef_pkg::PH_OPEN: esc_phase = tef_pkg::PH_HI;
            tef_pkg::PH_HI:
            begin
                hi_char   = c;
                esc_phase = tef_pkg::PH_LO;
            end
            tef_pkg::PH_LO:
            begin
                lo_char   = c;
                esc_phase = tef_pkg::PH_WAIT;
            end
            tef_pkg::PH_WAIT: esc_phase = tef_pkg::PH_EMIT;
            tef_pkg::PH_EMIT:
            begin
                v = escape_value(hi_char, lo_char);
                xor_acc = xor_acc ^ v;
                b = {1'b0, v};
                char_bytes.insert(char_bytes.size(), b);
                hi_char   = 8'h00;
                lo_char   = 8'h00;
                esc_phase = tef_pkg::PH_PASS;
                n_escapes++;
            end
            default:
            begin
                xor_acc = xor_acc ^ c;
                b = {1'b0, c};
                char_bytes.insert(char_bytes.size(), b);
            end
        endcase
    endtask

    // advance the mirror for one accepted character and queue its bytes
    task automatic predict_telegram(input cmd_char_t item);
        logic [7:0]     b;
        tef_pkg::beat_t e;
        char_bytes.delete();
        decode_char(item.ch);
        if (item.last)
        begin
            decode_char(tef_pkg::CH_CR);
            e = {1'b1, xor_acc};
            char_bytes.insert(char_bytes.size(), e);
            clear_decoder();
        end
        if (item.n_typed != 2'd0)
        begin
            for (int k = 0; k < int'(item.n_typed); k++)
            begin
                b = (k == 0) ? item.t0 : (k == 1) ? item.t1 : item.t2;
                e = {item.last && (k == int'(item.n_typed) - 1), b};
                pending_bytes.insert(pending_bytes.size(), e);
            end
        end
        else
        begin
            foreach (char_bytes[i])
                pending_bytes.insert(pending_bytes.size(), char_bytes[i]);
        end
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    task automatic push_char(input logic [7:0] c);
        cmd_char_t e;
        e = '{c, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00};
        cmd_chars.insert(cmd_chars.size(), e);
    endtask

    task automatic build_random(input int n_items);
        int         parts;
        logic [7:0] c;
        while (cmd_chars.size() < N_DIRECTED + n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // well-formed command: plain text and <hh> escapes
                parts = $urandom_range(1, 6);
                for (int p = 0; p < parts; p++)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        push_char(tef_pkg::CH_OPEN);
                        push_char(rand_hex_digit());
                        push_char(rand_hex_digit());
                        push_char(tef_pkg::CH_CLOSE);
                    end
                    else
                    begin
                        do
                            c = 8'($urandom);
                        while (c == tef_pkg::CH_OPEN || c == tef_pkg::CH_CLOSE);
                        push_char(c);
                    end
                end
                cmd_chars[cmd_chars.size() - 1].last = 1'b1;
            end
            else
            begin
                // noise, biased towards broken escapes
                parts = $urandom_range(1, 6);
                for (int p = 0; p < parts; p++)
                begin
                    case ($urandom_range(0, 3))
                        0: c = tef_pkg::CH_OPEN;
                        1: c = tef_pkg::CH_CLOSE;
                        2: c = rand_hex_digit();
                        default: c = 8'($urandom);
                    endcase
                    push_char(c);
                    if ($urandom_range(0, 5) == 0)
                        cmd_chars[cmd_chars.size() - 1].last = 1'b1;
                end
            end
        end
        push_char(8'h5A);
        cmd_chars[cmd_chars.size() - 1].last = 1'b1;
    endtask

    function automatic bit quiet_tail();
        return sent >= cmd_chars.size() - QUIET_TAIL;
    endfunction

    // source side
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && shown_idx == sent))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sent < cmd_chars.size())
            begin
                if (!quiet_tail() && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    shown_idx = sent;
                    s_tvalid <= 1'b1;
                    s_tdata  <= cmd_chars[sent].ch;
                    s_tlast  <= cmd_chars[sent].last;
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sink side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail() && $urandom_range(0, 9) == 0)
            begin
                snk_gap = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        tef_pkg::beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_telegram(cmd_chars[sent]);
                sent++;
            end
            if (m_tvalid && m_tready)
            begin
                n_bytes++;
                if (pending_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected transaction, byte %02h last %0b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = pending_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("byte_out %02h, want %02h",
                                                  m_tdata, want.data));
                    if (m_tlast !== want.is_chk)
                        report_mismatch($sformatf("is_checksum %0b, want %0b",
                                                  m_tlast, want.is_chk));
                    if (want.is_chk)
                        n_checksums++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("telegram_escape_xor_framer_tb: FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        clear_decoder();
        foreach (directed_tab[i])
            cmd_chars.insert(cmd_chars.size(), directed_tab[i]);
        build_random(N_RANDOM);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sent < cmd_chars.size() || pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (pending_bytes.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));

        $display("Sent %0d characters; checked %0d bytes, %0d decoded escapes, %0d checksums.",
                 sent, n_bytes, n_escapes, n_checksums);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("telegram_escape_xor_framer_tb: PASS");
        else
            $display("telegram_escape_xor_framer_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tef_pkg.sv
src/tef_step.sv
src/tef_out.sv
src/telegram_escape_xor_framer.sv
dv/telegram_escape_xor_framer_tb.sv
